// ===== rtl/core/midi_note_priority_stack_defines.svh =====
// Assertion macros for the note priority stack.
`ifndef MIDI_NOTE_PRIORITY_STACK_DEFINES_SVH
`define MIDI_NOTE_PRIORITY_STACK_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset.
`define MNPS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition implies another one on the same edge.
`define MNPS_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Check that a condition implies another one on the next edge.
`define MNPS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`else

`define MNPS_ASSERT(lbl, cond, msg)
`define MNPS_ASSERT_IMPL(lbl, pre, post, msg)
`define MNPS_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== rtl/core/mnps_pkg.sv =====
// Shared types and constants of the note priority stack.
`default_nettype none

package mnps_pkg;

	localparam int DEFAULT_STACK_DEPTH = 12;
	localparam int NUM_SLOTS           = 4;
	localparam logic [7:0] NO_NOTE      = 8'd128;
	localparam logic [4:0] OMNI_CHANNEL = 5'd16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 7;

	typedef enum logic [1:0] {
		PRIO_NEWEST  = 2'd0,
		PRIO_LOWEST  = 2'd1,
		PRIO_HIGHEST = 2'd2,
		PRIO_OLDEST  = 2'd3
	} prio_mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PRIORITY_MODE  = 3'd0,
		CFG_LISTEN_CHANNEL = 3'd1,
		CFG_NOTE_LOWEST    = 3'd2,
		CFG_NOTE_HIGHEST   = 3'd3,
		CFG_VELOCITY_FLOOR = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STK_HOLD,
		STK_FRONT,
		STK_PUSH,
		STK_REMOVE
	} stack_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILTER,
		ST_SEARCH,
		ST_MODIFY,
		ST_RANK,
		ST_COMMIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [3:0] midi_channel;
		logic [6:0] note_number;
		logic [6:0] velocity;
	} note_msg_t;

	typedef struct packed {
		logic [7:0] slot_a;
		logic [7:0] slot_b;
		logic [7:0] slot_c;
		logic [7:0] slot_d;
		logic       slots_changed;
		logic       accepted;
		logic       all_notes_off;
		logic [6:0] held_velocity;
		logic [3:0] held_count;
	} note_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mnps_stack.sv =====
// Recency stack of held notes with one read port and whole-row shift operations.
`default_nettype none

module mnps_stack #(
	parameter int STACK_DEPTH = mnps_pkg::DEFAULT_STACK_DEPTH,
	localparam int IDX_W = $clog2(STACK_DEPTH),
	localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mnps_pkg::stack_cmd_t cmd,
	input  wire logic [IDX_W-1:0]     pos,
	input  wire logic [6:0]           note,
	input  wire logic [IDX_W-1:0]     rd_addr,
	output logic      [6:0]           rd_data,
	output logic      [CNT_W-1:0]     count
);
	import mnps_pkg::*;

	logic [6:0]       held_q [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;

	assign rd_data = held_q[rd_addr];
	assign count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (cmd)
				STK_PUSH: begin
					if (count_q != CNT_W'(STACK_DEPTH)) count_q <= count_q + CNT_W'(1);
				end
				STK_REMOVE: count_q <= count_q - CNT_W'(1);
				STK_HOLD, STK_FRONT: ;
				default: ;
			endcase
		end
	end

	// Entries carry no reset; only those below the count are ever read.
	always_ff @(posedge clk) begin
		unique case (cmd)
			STK_FRONT: begin
				held_q[0] <= note;
				for (int i = 1; i < STACK_DEPTH; i++) begin
					if (IDX_W'(i) <= pos) held_q[i] <= held_q[i-1];
				end
			end
			STK_PUSH: begin
				// the oldest note falls off the end when full
				held_q[0] <= note;
				for (int i = 1; i < STACK_DEPTH; i++) held_q[i] <= held_q[i-1];
			end
			STK_REMOVE: begin
				for (int i = 0; i < STACK_DEPTH - 1; i++) begin
					if (IDX_W'(i) >= pos) held_q[i] <= held_q[i+1];
				end
			end
			STK_HOLD: ;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/mnps_rank.sv =====
// Slot insertion: folds one stack entry per step cycle into four ranked slots.
`default_nettype none

module mnps_rank (
	input  wire logic                                       clk,
	input  wire logic                                       clear,
	input  wire logic                                       step,
	input  wire mnps_pkg::prio_mode_t                       mode,
	input  wire logic [6:0]                                 note,
	output logic      [mnps_pkg::NUM_SLOTS-1:0][7:0]        fresh
);
	import mnps_pkg::*;

	logic [NUM_SLOTS-1:0][7:0] fresh_q;
	logic [NUM_SLOTS-1:0][7:0] fresh_d;
	logic [NUM_SLOTS-1:0]      takes;
	logic [7:0]                cand;
	logic                      placed;

	assign cand  = {1'b0, note};
	assign fresh = fresh_q;

	// An empty slot always takes the note; list modes never rank above a filled slot.
	always_comb begin
		for (int k = 0; k < NUM_SLOTS; k++) begin
			unique case (mode)
				PRIO_HIGHEST: takes[k] = (fresh_q[k] == NO_NOTE) || (cand > fresh_q[k]);
				PRIO_LOWEST:  takes[k] = (fresh_q[k] == NO_NOTE) || (cand < fresh_q[k]);
				PRIO_NEWEST, PRIO_OLDEST: takes[k] = (fresh_q[k] == NO_NOTE);
				default: takes[k] = 1'b0;
			endcase
		end
	end

	always_comb begin
		placed = 1'b0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (placed) begin
				fresh_d[k] = fresh_q[(k > 0) ? k - 1 : 0];
			end else if (takes[k]) begin
				fresh_d[k] = cand;
				placed     = 1'b1;
			end else begin
				fresh_d[k] = fresh_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			fresh_q <= {NUM_SLOTS{NO_NOTE}};
		end else if (step) begin
			fresh_q <= fresh_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/midi_note_priority_stack.sv =====
// Top level of the monophonic note priority stack: sequencer, filters, registers.
//
// Usage: note messages enter on in_data with in_valid; a transfer happens when
// in_valid is high and in_stall is low. Each message yields exactly one result
// on out_data, a transfer when out_valid is high and out_stall is low.
// Registers are written through cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and writes are meant for idle periods.
// Timing: in_stall rises on the input transfer, and the result is loaded on the
// edge where it drops, so latency equals the busy time. A rejected message or a
// note off on an empty stack goes straight to the result; a note off of an unheld
// note walks the held notes first. Otherwise the search walk (none on an empty
// stack) and the slot walk (none when the note is already newest) through the
// single read port set the busy time; no new message is taken meanwhile.
// A finished result sits in the output register while the next message is
// taken; when the receiver stalls and a second result is ready, the block
// holds in_stall high until the output register frees.
// Reset clears the stack count, sets all slots to no note (128), clears the
// held velocity and returns the registers to their defaults (omni channel).
`default_nettype none
`include "midi_note_priority_stack_defines.svh"

module midi_note_priority_stack #(
	parameter int STACK_DEPTH = mnps_pkg::DEFAULT_STACK_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire mnps_pkg::note_msg_t                 in_data,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output mnps_pkg::note_result_t                   out_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mnps_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [mnps_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mnps_pkg::*;

	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	state_t state_q, state_d;

	prio_mode_t mode_q;
	logic [4:0] listen_q;
	logic [6:0] note_lo_q;
	logic [6:0] note_hi_q;
	logic [6:0] vel_floor_q;

	note_msg_t                 item_q;
	logic                      ok_q;
	logic                      found_q;
	logic [IDX_W-1:0]          pos_q;
	logic [CNT_W-1:0]          walk_q;
	logic                      changed_q;
	logic                      all_off_q;
	logic [6:0]                last_vel_q;
	logic [NUM_SLOTS-1:0][7:0] slots_q;
	logic                      out_valid_q;
	note_result_t              out_data_q;

	stack_cmd_t                stack_cmd;
	logic [IDX_W-1:0]          rd_addr;
	logic [6:0]                rd_data;
	logic [CNT_W-1:0]          stack_count;
	logic [CNT_W-1:0]          walk_next;
	logic [CNT_W-1:0]          walk_rev;
	logic                      rank_clear;
	logic                      rank_step;
	logic [NUM_SLOTS-1:0][7:0] fresh;
	logic                      pass;
	logic                      note_on;
	logic                      match;
	logic                      load_out;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign note_on   = (item_q.velocity != 7'd0);
	assign walk_next = walk_q + CNT_W'(1);
	assign walk_rev  = stack_count - walk_q - CNT_W'(1);
	assign match     = (rd_data == item_q.note_number);
	assign load_out  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	always_comb begin
		pass = 1'b1;
		if (listen_q != OMNI_CHANNEL && {1'b0, item_q.midi_channel} != listen_q) pass = 1'b0;
		if (note_lo_q != 7'd0 && item_q.note_number < note_lo_q) pass = 1'b0;
		if (note_hi_q != 7'd0 && item_q.note_number > note_hi_q) pass = 1'b0;
		if (note_on && vel_floor_q != 7'd0 && item_q.velocity < vel_floor_q) pass = 1'b0;
	end

	mnps_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (stack_cmd),
		.pos     (pos_q),
		.note    (item_q.note_number),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.count   (stack_count)
	);

	mnps_rank u_rank (
		.clk   (clk),
		.clear (rank_clear),
		.step  (rank_step),
		.mode  (mode_q),
		.note  (rd_data),
		.fresh (fresh)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		stack_cmd  = STK_HOLD;
		rank_clear = 1'b0;
		rank_step  = 1'b0;
		rd_addr    = walk_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_FILTER;
			end
			ST_FILTER: begin
				priority if (!pass)                         state_d = ST_FINISH;
				else if (stack_count == '0 && note_on)      state_d = ST_MODIFY;
				else if (stack_count == '0)                 state_d = ST_FINISH;
				else                                        state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (match || walk_next == stack_count) state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				rank_clear = 1'b1;
				if (note_on) begin
					// already newest: nothing moves and the slots stay
					if (found_q && pos_q == '0) begin
						state_d = ST_FINISH;
					end else begin
						stack_cmd = found_q ? STK_FRONT : STK_PUSH;
						state_d   = ST_RANK;
					end
				end else if (found_q) begin
					stack_cmd = STK_REMOVE;
					state_d   = ST_RANK;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_RANK: begin
				if (mode_q == PRIO_OLDEST) rd_addr = walk_rev[IDX_W-1:0];
				if (walk_q == stack_count) state_d = ST_COMMIT;
				else                       rank_step = 1'b1;
			end
			ST_COMMIT: state_d = ST_FINISH;
			ST_FINISH: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= PRIO_NEWEST;
			listen_q    <= OMNI_CHANNEL;
			note_lo_q   <= '0;
			note_hi_q   <= '0;
			vel_floor_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PRIORITY_MODE:  mode_q      <= prio_mode_t'(cfg_data[1:0]);
				CFG_LISTEN_CHANNEL: listen_q    <= cfg_data[4:0];
				CFG_NOTE_LOWEST:    note_lo_q   <= cfg_data;
				CFG_NOTE_HIGHEST:   note_hi_q   <= cfg_data;
				CFG_VELOCITY_FLOOR: vel_floor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q        <= 1'b0;
			found_q     <= 1'b0;
			pos_q       <= '0;
			walk_q      <= '0;
			changed_q   <= 1'b0;
			all_off_q   <= 1'b0;
			last_vel_q  <= '0;
			slots_q     <= {NUM_SLOTS{NO_NOTE}};
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_FILTER: begin
					ok_q      <= pass;
					found_q   <= 1'b0;
					walk_q    <= '0;
					changed_q <= 1'b0;
					all_off_q <= 1'b0;
					if (pass && note_on) last_vel_q <= item_q.velocity;
				end
				ST_SEARCH: begin
					if (match) begin
						found_q <= 1'b1;
						pos_q   <= walk_q[IDX_W-1:0];
					end else begin
						walk_q <= walk_next;
					end
				end
				ST_MODIFY: walk_q <= '0;
				ST_RANK: begin
					if (rank_step) walk_q <= walk_next;
				end
				ST_COMMIT: begin
					changed_q <= (fresh != slots_q);
					slots_q   <= fresh;
					all_off_q <= !note_on && (stack_count == '0);
				end
				ST_IDLE, ST_FINISH: ;
				default: ;
			endcase

			// hold the result until the receiver takes the transfer
			if (load_out)        out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) item_q <= in_data;
		if (load_out) begin
			out_data_q.slot_a        <= slots_q[0];
			out_data_q.slot_b        <= slots_q[1];
			out_data_q.slot_c        <= slots_q[2];
			out_data_q.slot_d        <= slots_q[3];
			out_data_q.slots_changed <= changed_q;
			out_data_q.accepted      <= ok_q;
			out_data_q.all_notes_off <= all_off_q;
			out_data_q.held_velocity <= last_vel_q;
			out_data_q.held_count    <= 4'(stack_count);
		end
	end

	`MNPS_ASSERT(a_count_bound, stack_count <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
	`MNPS_ASSERT_NEXT(a_accept_filter, in_valid && !in_stall,
		state_q == ST_FILTER, "transfer not filtered")
	`MNPS_ASSERT_IMPL(a_reject_quiet, out_valid && !out_data.accepted,
		!out_data.slots_changed && !out_data.all_notes_off, "rejected message changed state")
	`MNPS_ASSERT_IMPL(a_all_off_empty, out_valid && out_data.all_notes_off,
		out_data.held_count == 4'd0 && out_data.slot_a == NO_NOTE, "all notes off with notes held")

endmodule

`default_nettype wire
